// ----- hw/rtl/sst_pkg.sv -----
// Shared types, constants and per-byte scanning functions for the source tokenizer.
package sst_pkg;

	localparam int MAX_TOKEN_COUNT = 1024;
	localparam int MAX_VALUE_BYTES = 255;
	localparam int TOK_W = $clog2(MAX_TOKEN_COUNT + 1);
	localparam int LEN_W = $clog2(MAX_VALUE_BYTES + 1);

	localparam int KW_COUNT = 14;
	localparam logic [KW_COUNT-1:0] KW_ALL = '1;

	localparam int RES_MAX = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	// Keywords are right-justified strings, so character p of keyword k sits
	// at byte (KW_LEN[k] - 1 - p) counted from the least significant end.
	localparam logic [79:0] KW_TEXT [KW_COUNT] = '{
		"let", "set", "check", "othercheck", "other", "echo", "loop",
		"stop", "funcdo", "done", "run", "catch", "module", "return"
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd3, 4'd5, 4'd10, 4'd5, 4'd4, 4'd4,
		4'd4, 4'd6, 4'd4, 4'd3, 4'd5, 4'd6, 4'd6
	};

	typedef enum logic [2:0] {
		M_IDLE,
		M_WORD,
		M_NUM,
		M_STR,
		M_PEND,
		M_ERR
	} mode_t;

	typedef enum logic [1:0] {
		K_BYTE,
		K_END,
		K_ERR,
		K_DONE
	} kind_t;

	typedef enum logic [2:0] {
		C_KEYWORD,
		C_IDENT,
		C_NUMBER,
		C_STRING,
		C_OPERATOR
	} class_t;

	typedef enum logic [2:0] {
		E_NONE,
		E_UNKNOWN,
		E_UNTERM,
		E_TOO_MANY,
		E_TOO_LONG
	} err_t;

	typedef struct packed {
		kind_t kind;
		logic [7:0] tok_byte;
		class_t cls;
		logic [3:0] kwi;
		err_t err;
	} res_t;

	typedef struct packed {
		res_t r;
		logic [15:0] line;
		logic [15:0] col;
		logic last;
	} entry_t;

	typedef struct packed {
		mode_t mode;
		logic [LEN_W-1:0] len;
		logic [KW_COUNT-1:0] kw;
		logic [15:0] line;
		logic [15:0] col;
		logic [TOK_W-1:0] ntok;
		logic [1:0] n;
		res_t [RES_MAX-1:0] res;
	} work_t;

	function automatic logic is_alpha(logic [7:0] c);
		return (c inside {["a":"z"]}) || (c inside {["A":"Z"]});
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c inside {["0":"9"]};
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return (c == " ") || (c inside {[8'd9:8'd13]});
	endfunction

	function automatic logic is_op(logic [7:0] c);
		return c inside {"=", "+", "-", ">", "*", "/", ",", "{", "}", ":", ";",
			"(", ")", "[", "]", "?", "%"};
	endfunction

	function automatic logic is_pair_lead(logic [7:0] c);
		return c inside {"+", "-", "*", "/", "%"};
	endfunction

	function automatic work_t emit(work_t w_in, kind_t kind, logic [7:0] b, class_t cls,
		logic [3:0] kwi, err_t err);
		work_t w;
		w = w_in;
		if (w.n < 2'd3) begin
			w.res[w.n].kind = kind;
			w.res[w.n].tok_byte = b;
			w.res[w.n].cls = cls;
			w.res[w.n].kwi = kwi;
			w.res[w.n].err = err;
			w.n = w.n + 2'd1;
		end
		return w;
	endfunction

	function automatic work_t adv_col(work_t w_in);
		work_t w;
		w = w_in;
		if (w.col != 16'hFFFF) begin
			w.col = w.col + 16'd1;
		end
		return w;
	endfunction

	function automatic work_t add_byte(work_t w_in, logic [7:0] c);
		work_t w;
		w = w_in;
		if (w.len >= LEN_W'(MAX_VALUE_BYTES)) begin
			w = emit(w, K_ERR, 8'd0, C_KEYWORD, 4'd0, E_TOO_LONG);
			w.mode = M_ERR;
		end else begin
			w = emit(w, K_BYTE, c, C_KEYWORD, 4'd0, E_NONE);
			w.len = w.len + LEN_W'(1);
		end
		return w;
	endfunction

	function automatic work_t narrow(work_t w_in, logic [7:0] c);
		work_t w;
		w = w_in;
		for (int k = 0; k < KW_COUNT; k++) begin
			if (w.len >= LEN_W'(KW_LEN[k])) begin
				w.kw[k] = 1'b0;
			end else if (KW_TEXT[k][8 * (int'(KW_LEN[k]) - 1 - int'(w.len[3:0])) +: 8] != c) begin
				w.kw[k] = 1'b0;
			end
		end
		return w;
	endfunction

	function automatic work_t close_token(work_t w_in, class_t cls_in);
		work_t w;
		class_t cls;
		logic [3:0] kwi;
		w = w_in;
		cls = cls_in;
		kwi = 4'd0;
		if (w.ntok >= TOK_W'(MAX_TOKEN_COUNT)) begin
			w = emit(w, K_ERR, 8'd0, C_KEYWORD, 4'd0, E_TOO_MANY);
			w.mode = M_ERR;
		end else begin
			if (cls_in == C_IDENT) begin
				for (int k = 0; k < KW_COUNT; k++) begin
					if (w.kw[k] && (LEN_W'(KW_LEN[k]) == w.len)) begin
						cls = C_KEYWORD;
						kwi = 4'(k);
					end
				end
			end
			w = emit(w, K_END, 8'd0, cls, kwi, E_NONE);
			w.ntok = w.ntok + TOK_W'(1);
			w.mode = M_IDLE;
			w.len = '0;
			w.kw = KW_ALL;
		end
		return w;
	endfunction

	function automatic work_t start_byte(work_t w_in, logic [7:0] c);
		work_t w;
		w = w_in;
		w.len = '0;
		w.kw = KW_ALL;
		if (is_space(c)) begin
			if (c == 8'h0a) begin
				if (w.line != 16'hFFFF) begin
					w.line = w.line + 16'd1;
				end
				w.col = 16'd1;
			end else begin
				w = adv_col(w);
			end
		end else if (is_alpha(c)) begin
			w.mode = M_WORD;
			w = narrow(w, c);
			w = add_byte(w, c);
			if (w.mode != M_ERR) begin
				w = adv_col(w);
			end
		end else if (is_digit(c)) begin
			w.mode = M_NUM;
			w = add_byte(w, c);
			if (w.mode != M_ERR) begin
				w = adv_col(w);
			end
		end else if (c == "\"") begin
			w.mode = M_STR;
			w = adv_col(w);
		end else if (is_op(c)) begin
			w = adv_col(w);
			if (is_pair_lead(c)) begin
				w.mode = M_PEND;
				w = add_byte(w, c);
			end else begin
				w = add_byte(w, c);
				if (w.mode != M_ERR) begin
					w = close_token(w, C_OPERATOR);
				end
			end
		end else begin
			w = emit(w, K_ERR, 8'd0, C_KEYWORD, 4'd0, E_UNKNOWN);
			w.mode = M_ERR;
		end
		return w;
	endfunction

	function automatic work_t step(work_t w_in, logic [7:0] c, logic eot);
		work_t w;
		w = w_in;
		w.n = 2'd0;
		w.res = '0;
		if (eot) begin
			case (w.mode)
				M_WORD: w = close_token(w, C_IDENT);
				M_NUM: w = close_token(w, C_NUMBER);
				M_PEND: w = close_token(w, C_OPERATOR);
				M_STR: w = emit(w, K_ERR, 8'd0, C_KEYWORD, 4'd0, E_UNTERM);
				default: ;
			endcase
			w = emit(w, K_DONE, 8'd0, C_KEYWORD, 4'd0, E_NONE);
			w.mode = M_IDLE;
			w.len = '0;
			w.kw = KW_ALL;
			w.line = 16'd1;
			w.col = 16'd1;
			w.ntok = '0;
		end else begin
			case (w.mode)
				M_WORD: begin
					if (is_alpha(c) || is_digit(c) || (c == "_")) begin
						w = narrow(w, c);
						w = add_byte(w, c);
						if (w.mode != M_ERR) begin
							w = adv_col(w);
						end
					end else begin
						w = close_token(w, C_IDENT);
						if (w.mode == M_IDLE) begin
							w = start_byte(w, c);
						end
					end
				end
				M_NUM: begin
					if (is_digit(c) || (c == ".")) begin
						w = add_byte(w, c);
						if (w.mode != M_ERR) begin
							w = adv_col(w);
						end
					end else begin
						w = close_token(w, C_NUMBER);
						if (w.mode == M_IDLE) begin
							w = start_byte(w, c);
						end
					end
				end
				M_STR: begin
					w = adv_col(w);
					if (c == "\"") begin
						w = close_token(w, C_STRING);
					end else begin
						w = add_byte(w, c);
					end
				end
				M_PEND: begin
					if (c == ">") begin
						w = adv_col(w);
						w = add_byte(w, c);
						if (w.mode != M_ERR) begin
							w = close_token(w, C_OPERATOR);
						end
					end else begin
						w = close_token(w, C_OPERATOR);
						if (w.mode == M_IDLE) begin
							w = start_byte(w, c);
						end
					end
				end
				M_IDLE: w = start_byte(w, c);
				default: ;
			endcase
		end
		return w;
	endfunction

endpackage

// ----- hw/rtl/streaming_source_tokenizer.sv -----
// Top level of the streaming source tokenizer: input register, scan step and result queue.
//
// Source bytes enter on the text channel (ch, end_of_text) with text_valid and
// text_stall; results leave on the result channel (kind, token_byte, token_class,
// keyword_index, error_code, line, column, last) with res_valid and res_stall.
// An accepted item sits in an input register; when the queue has room, the scan
// logic turns it into zero to three results, which are written together into a
// four-entry result queue while the scanner state updates.
// An item's results are offered after it passes the input register and result queue.
// One item is taken per cycle as long as the queue holds at most one result
// after the current cycle's read, so a steady stream of one result per byte
// runs at full rate; results leave at one per cycle while res_stall is low, so
// once the queue's one spare entry is used, each further extra result stalls the input.
// When the receiver stalls, the queue fills and text_stall rises while the
// registered item waits for room; nothing is dropped or repeated.
// Reset empties the input register and the queue, sets the scanner idle with
// line and column at one and the token count at zero. An end_of_text item
// closes any open word, number or operator token, reports an open string
// as unterminated, reports text done and returns the scanner to that same state.
module streaming_source_tokenizer (
	input  logic clk,
	input  logic arst_n,
	input  logic text_valid,
	output logic text_stall,
	input  logic [7:0] ch,
	input  logic end_of_text,
	output logic res_valid,
	input  logic res_stall,
	output logic [1:0] kind,
	output logic [7:0] token_byte,
	output logic [2:0] token_class,
	output logic [3:0] keyword_index,
	output logic [2:0] error_code,
	output logic [15:0] line,
	output logic [15:0] column,
	output logic last
);

	logic s1_valid_q;
	logic [7:0] ch_s1;
	logic eot_s1;

	sst_pkg::mode_t mode_q;
	logic [sst_pkg::LEN_W-1:0] len_q;
	logic [sst_pkg::KW_COUNT-1:0] kw_q;
	logic [15:0] line_q;
	logic [15:0] col_q;
	logic [sst_pkg::TOK_W-1:0] ntok_q;

	sst_pkg::entry_t fifo_q [sst_pkg::FIFO_DEPTH];
	logic [sst_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [sst_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [sst_pkg::CNT_W-1:0] count_q;

	sst_pkg::work_t w_cur;
	sst_pkg::work_t w_next;
	logic pop;
	logic go;
	logic accept_in;
	logic [1:0] push_n;
	sst_pkg::entry_t head;

	always_comb begin
		w_cur.mode = mode_q;
		w_cur.len = len_q;
		w_cur.kw = kw_q;
		w_cur.line = line_q;
		w_cur.col = col_q;
		w_cur.ntok = ntok_q;
		w_cur.n = 2'd0;
		w_cur.res = '0;
		w_next = sst_pkg::step(w_cur, ch_s1, eot_s1);
	end

	always_comb begin
		pop = res_valid && !res_stall;
		go = s1_valid_q && ((count_q - sst_pkg::CNT_W'(pop)) <= sst_pkg::CNT_W'(1));
		text_stall = s1_valid_q && !go;
		accept_in = text_valid && !text_stall;
		push_n = go ? w_next.n : 2'd0;
		head = fifo_q[rd_ptr_q];
		res_valid = count_q != '0;
		kind = head.r.kind;
		token_byte = head.r.tok_byte;
		token_class = head.r.cls;
		keyword_index = head.r.kwi;
		error_code = head.r.err;
		line = head.line;
		column = head.col;
		last = head.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			mode_q <= sst_pkg::M_IDLE;
			len_q <= '0;
			kw_q <= sst_pkg::KW_ALL;
			line_q <= 16'd1;
			col_q <= 16'd1;
			ntok_q <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (accept_in) begin
				s1_valid_q <= 1'b1;
			end else if (go) begin
				s1_valid_q <= 1'b0;
			end
			if (go) begin
				mode_q <= w_next.mode;
				len_q <= w_next.len;
				kw_q <= w_next.kw;
				line_q <= w_next.line;
				col_q <= w_next.col;
				ntok_q <= w_next.ntok;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + sst_pkg::FIFO_AW'(1);
			end
			wr_ptr_q <= wr_ptr_q + sst_pkg::FIFO_AW'(push_n);
			count_q <= count_q + sst_pkg::CNT_W'(push_n) - sst_pkg::CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			ch_s1 <= ch;
			eot_s1 <= end_of_text;
		end
		for (int i = 0; i < sst_pkg::RES_MAX; i++) begin
			if (2'(i) < push_n) begin
				fifo_q[wr_ptr_q + sst_pkg::FIFO_AW'(i)] <= '{
					r: w_next.res[i],
					line: line_q,
					col: col_q,
					last: (2'(i) == (push_n - 2'd1))
				};
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sst_pkg::CNT_W'(sst_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		go && eot_s1 |=> (mode_q == sst_pkg::M_IDLE) && (line_q == 16'd1)
			&& (col_q == 16'd1) && (ntok_q == '0))
		else $error("scanner not returned to start after end of text");

	assert property (@(posedge clk) disable iff (!arst_n)
		go && (mode_q == sst_pkg::M_ERR) && !eot_s1 |-> (w_next.n == 2'd0))
		else $error("result produced while skipping after an error");

	assert property (@(posedge clk) disable iff (!arst_n)
		ntok_q <= sst_pkg::TOK_W'(sst_pkg::MAX_TOKEN_COUNT))
		else $error("token count beyond its limit");

endmodule

// ----- tb/tb_streaming_source_tokenizer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the streaming source tokenizer, checked against a scanning predictor.
module tb_streaming_source_tokenizer;

	localparam int STALL_LIMIT = 1000;
	localparam int PROBE_ROWS = 26;
	localparam int RANDOM_ITEMS = 82;

	typedef struct packed {
		sst_pkg::kind_t kind;
		logic [7:0] tbyte;
		sst_pkg::class_t cls;
		logic [3:0] kwi;
		sst_pkg::err_t err;
		logic [15:0] ln;
		logic [15:0] col;
		logic lst;
	} tok_res_t;

	typedef struct packed {
		logic [7:0] c;
		logic e;
		logic fixed;
		sst_pkg::kind_t kind;
		sst_pkg::err_t err;
	} probe_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_valid = 1'b0;
	logic text_stall;
	logic [7:0] ch = 8'h00;
	logic end_of_text = 1'b0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] token_byte;
	logic [2:0] token_class;
	logic [3:0] keyword_index;
	logic [2:0] error_code;
	logic [15:0] line;
	logic [15:0] column;
	logic last;

	streaming_source_tokenizer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.ch(ch),
		.end_of_text(end_of_text),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.kind(kind),
		.token_byte(token_byte),
		.token_class(token_class),
		.keyword_index(keyword_index),
		.error_code(error_code),
		.line(line),
		.column(column),
		.last(last)
	);

	always #5 clk = ~clk;

	string keyword_text [14] = '{
		"let", "set", "check", "othercheck", "other", "echo", "loop",
		"stop", "funcdo", "done", "run", "catch", "module", "return"
	};
	string field_name [8] = '{
		"kind", "token_byte", "token_class", "keyword_index",
		"error_code", "line", "column", "last"
	};
	string op_chars = "=+->*/,{}:;()[]?%";
	string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
	logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};

	// Rows marked fixed carry their single result, which always sits at line 1, column 1.
	probe_row_t probe_rows [PROBE_ROWS] = '{
		'{8'h00, 1'b0, 1'b1, sst_pkg::K_ERR, sst_pkg::E_UNKNOWN},
		'{8'h00, 1'b1, 1'b1, sst_pkg::K_DONE, sst_pkg::E_NONE},
		'{8'hFF, 1'b0, 1'b1, sst_pkg::K_ERR, sst_pkg::E_UNKNOWN},
		'{"a", 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{8'hFF, 1'b1, 1'b1, sst_pkg::K_DONE, sst_pkg::E_NONE},
		'{"\"", 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{8'h00, 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{8'hFF, 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{8'h0a, 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{8'h00, 1'b1, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{"l", 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{"e", 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{"t", 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{8'h0a, 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{"-", 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{">", 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{"%", 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{"9", 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{".", 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{".", 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{"_", 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{8'h5A, 1'b1, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{"+", 1'b0, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{8'h00, 1'b1, 1'b0, sst_pkg::K_BYTE, sst_pkg::E_NONE},
		'{".", 1'b0, 1'b1, sst_pkg::K_ERR, sst_pkg::E_UNKNOWN},
		'{8'hA5, 1'b1, 1'b1, sst_pkg::K_DONE, sst_pkg::E_NONE}
	};

	sst_pkg::mode_t scan_state = sst_pkg::M_IDLE;
	int tok_len = 0;
	logic [13:0] kw_live = '1;
	logic [15:0] cur_line = 16'd1;
	logic [15:0] cur_col = 16'd1;
	int tok_count = 0;
	logic [15:0] snap_line;
	logic [15:0] snap_col;
	tok_res_t step_results [$];
	tok_res_t pending_results [$];

	int mismatches = 0;
	int live_items = 0;
	int burst_left = 1;
	int rx_cycle = 0;
	int stall_style = 0;
	int idle_cycles = 0;

	function automatic logic letter_ch(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic digit_ch(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic blank_ch(logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic op_ch(logic [7:0] c);
		case (c)
			"=", "+", "-", ">", "*", "/", ",", "{", "}", ":", ";", "(", ")", "[", "]", "?",
			"%": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic pair_ch(logic [7:0] c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "%";
	endfunction

	function automatic void post_result(sst_pkg::kind_t k, logic [7:0] b, sst_pkg::class_t cl,
		logic [3:0] i, sst_pkg::err_t er);
		tok_res_t r;
		r.kind = k;
		r.tbyte = b;
		r.cls = cl;
		r.kwi = i;
		r.err = er;
		r.ln = snap_line;
		r.col = snap_col;
		r.lst = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void col_up();
		if (cur_col != 16'hFFFF) begin
			cur_col = cur_col + 16'd1;
		end
	endfunction

	function automatic void reset_token();
		tok_len = 0;
		kw_live = '1;
	endfunction

	function automatic void restart_scan();
		scan_state = sst_pkg::M_IDLE;
		reset_token();
		cur_line = 16'd1;
		cur_col = 16'd1;
		tok_count = 0;
	endfunction

	function automatic logic take_byte(logic [7:0] c);
		if (tok_len >= sst_pkg::MAX_VALUE_BYTES) begin
			post_result(sst_pkg::K_ERR, 8'h00, sst_pkg::C_KEYWORD, 4'd0, sst_pkg::E_TOO_LONG);
			scan_state = sst_pkg::M_ERR;
			return 1'b0;
		end
		post_result(sst_pkg::K_BYTE, c, sst_pkg::C_KEYWORD, 4'd0, sst_pkg::E_NONE);
		tok_len++;
		return 1'b1;
	endfunction

	function automatic void prune_keywords(logic [7:0] c);
		for (int k = 0; k < 14; k++) begin
			if (tok_len >= keyword_text[k].len() || keyword_text[k][tok_len] != c) begin
				kw_live[k] = 1'b0;
			end
		end
	endfunction

	function automatic logic end_token(sst_pkg::class_t cl_in);
		sst_pkg::class_t cl;
		logic [3:0] kwi;
		cl = cl_in;
		kwi = 4'd0;
		if (tok_count >= sst_pkg::MAX_TOKEN_COUNT) begin
			post_result(sst_pkg::K_ERR, 8'h00, sst_pkg::C_KEYWORD, 4'd0, sst_pkg::E_TOO_MANY);
			scan_state = sst_pkg::M_ERR;
			return 1'b0;
		end
		if (cl_in == sst_pkg::C_IDENT) begin
			for (int k = 0; k < 14; k++) begin
				if (kw_live[k] && keyword_text[k].len() == tok_len) begin
					cl = sst_pkg::C_KEYWORD;
					kwi = 4'(k);
				end
			end
		end
		post_result(sst_pkg::K_END, 8'h00, cl, kwi, sst_pkg::E_NONE);
		tok_count++;
		scan_state = sst_pkg::M_IDLE;
		reset_token();
		return 1'b1;
	endfunction

	function automatic void open_token(logic [7:0] c);
		reset_token();
		if (blank_ch(c)) begin
			if (c == 8'h0a) begin
				if (cur_line != 16'hFFFF) begin
					cur_line = cur_line + 16'd1;
				end
				cur_col = 16'd1;
			end else begin
				col_up();
			end
		end else if (letter_ch(c)) begin
			scan_state = sst_pkg::M_WORD;
			prune_keywords(c);
			if (take_byte(c)) begin
				col_up();
			end
		end else if (digit_ch(c)) begin
			scan_state = sst_pkg::M_NUM;
			if (take_byte(c)) begin
				col_up();
			end
		end else if (c == "\"") begin
			scan_state = sst_pkg::M_STR;
			col_up();
		end else if (op_ch(c)) begin
			col_up();
			if (pair_ch(c)) begin
				scan_state = sst_pkg::M_PEND;
				void'(take_byte(c));
			end else if (take_byte(c)) begin
				void'(end_token(sst_pkg::C_OPERATOR));
			end
		end else begin
			post_result(sst_pkg::K_ERR, 8'h00, sst_pkg::C_KEYWORD, 4'd0, sst_pkg::E_UNKNOWN);
			scan_state = sst_pkg::M_ERR;
		end
	endfunction

	function automatic void scan_item(logic [7:0] c, logic e);
		step_results.delete();
		snap_line = cur_line;
		snap_col = cur_col;
		if (e) begin
			case (scan_state)
				sst_pkg::M_WORD: void'(end_token(sst_pkg::C_IDENT));
				sst_pkg::M_NUM: void'(end_token(sst_pkg::C_NUMBER));
				sst_pkg::M_PEND: void'(end_token(sst_pkg::C_OPERATOR));
				sst_pkg::M_STR: post_result(sst_pkg::K_ERR, 8'h00, sst_pkg::C_KEYWORD, 4'd0,
					sst_pkg::E_UNTERM);
				default: ;
			endcase
			post_result(sst_pkg::K_DONE, 8'h00, sst_pkg::C_KEYWORD, 4'd0, sst_pkg::E_NONE);
			restart_scan();
		end else begin
			case (scan_state)
				sst_pkg::M_WORD: begin
					if (letter_ch(c) || digit_ch(c) || c == "_") begin
						prune_keywords(c);
						if (take_byte(c)) begin
							col_up();
						end
					end else if (end_token(sst_pkg::C_IDENT)) begin
						open_token(c);
					end
				end
				sst_pkg::M_NUM: begin
					if (digit_ch(c) || c == ".") begin
						if (take_byte(c)) begin
							col_up();
						end
					end else if (end_token(sst_pkg::C_NUMBER)) begin
						open_token(c);
					end
				end
				sst_pkg::M_STR: begin
					col_up();
					if (c == "\"") begin
						void'(end_token(sst_pkg::C_STRING));
					end else begin
						void'(take_byte(c));
					end
				end
				sst_pkg::M_PEND: begin
					if (c == ">") begin
						col_up();
						if (take_byte(c)) begin
							void'(end_token(sst_pkg::C_OPERATOR));
						end
					end else if (end_token(sst_pkg::C_OPERATOR)) begin
						open_token(c);
					end
				end
				sst_pkg::M_IDLE: open_token(c);
				default: ;
			endcase
		end
		if (step_results.size() > 0) begin
			step_results[step_results.size() - 1].lst = 1'b1;
		end
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic push_text(input logic [7:0] c, input logic e, input logic use_fixed,
		input tok_res_t fixed);
		int gap;
		text_valid <= 1'b1;
		ch <= c;
		end_of_text <= e;
		@(posedge clk);
		while (text_stall) begin
			@(posedge clk);
		end
		live_items++;
		scan_item(c, e);
		if (use_fixed) begin
			step_results.delete();
			step_results.push_back(fixed);
		end
		foreach (step_results[i]) begin
			pending_results.push_back(step_results[i]);
		end
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				text_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_ch(input logic [7:0] c, input logic e);
		push_text(c, e, 1'b0, '0);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_ch(s[i], 1'b0);
		end
	endtask

	task automatic send_eot();
		send_ch(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_sep();
		case ($urandom_range(0, 5))
			3: send_ch(op_chars[$urandom_range(0, 16)], 1'b0);
			4: ;
			default: send_ch(blanks[$urandom_range(0, 5)], 1'b0);
		endcase
	endtask

	task automatic send_piece();
		int pick;
		int n;
		string w;
		logic [7:0] b;
		pick = $urandom_range(0, 18);
		if (pick < 4) begin
			send_text(keyword_text[$urandom_range(0, 13)]);
			send_sep();
		end else if (pick < 7) begin
			w = keyword_text[$urandom_range(0, 13)];
			case ($urandom_range(0, 2))
				0: send_text(w.substr(0, w.len() - 2));
				1: begin
					send_text(w);
					send_ch(ident_chars[$urandom_range(0, 62)], 1'b0);
				end
				default: begin
					send_ch(ident_chars[$urandom_range(0, 51)], 1'b0);
					n = $urandom_range(0, 7);
					repeat (n) send_ch(ident_chars[$urandom_range(0, 62)], 1'b0);
				end
			endcase
			send_sep();
		end else if (pick < 9) begin
			send_ch(8'("0" + $urandom_range(0, 9)), 1'b0);
			n = $urandom_range(0, 5);
			repeat (n) begin
				b = ($urandom_range(0, 3) == 0) ? "." : 8'("0" + $urandom_range(0, 9));
				send_ch(b, 1'b0);
			end
			send_sep();
		end else if (pick < 11) begin
			send_ch("\"", 1'b0);
			n = $urandom_range(0, 6);
			repeat (n) send_ch(8'($urandom_range(0, 255)), 1'b0);
			if ($urandom_range(0, 5) != 0) begin
				send_ch("\"", 1'b0);
			end
		end else if (pick < 14) begin
			b = op_chars[$urandom_range(0, 16)];
			send_ch(b, 1'b0);
			if (pair_ch(b) && $urandom_range(0, 1) == 1) begin
				send_ch(">", 1'b0);
			end
		end else if (pick < 16) begin
			send_ch(blanks[$urandom_range(0, 5)], 1'b0);
		end else if (pick < 17) begin
			send_ch(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			send_eot();
		end
	endtask

	task automatic hold_until_drained();
		text_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic check_result();
		tok_res_t want;
		logic [15:0] got_f [8];
		logic [15:0] want_f [8];
		if (pending_results.size() == 0) begin
			note_mismatch($sformatf("result kind %0d at %0d:%0d with nothing expected",
				kind, line, column));
		end else begin
			want = pending_results.pop_front();
			got_f = '{16'(kind), 16'(token_byte), 16'(token_class), 16'(keyword_index),
				16'(error_code), line, column, 16'(last)};
			want_f = '{16'(want.kind), 16'(want.tbyte), 16'(want.cls), 16'(want.kwi),
				16'(want.err), want.ln, want.col, 16'(want.lst)};
			for (int k = 0; k < 8; k++) begin
				if (got_f[k] !== want_f[k]) begin
					note_mismatch($sformatf("%s is %0h, expected %0h (item at %0d:%0d)",
						field_name[k], got_f[k], want_f[k], want.ln, want.col));
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (res_valid === 1'b1 && res_stall === 1'b0) begin
			check_result();
		end
		if (rx_cycle % 64 == 0) begin
			stall_style = $urandom_range(0, 3);
		end
		case (stall_style)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 1) == 1);
			2: res_stall <= ($urandom_range(0, 3) != 0);
			default: res_stall <= ((rx_cycle % 7) < 3);
		endcase
		rx_cycle++;
	end

	always @(posedge clk) begin
		if ((text_valid && !text_stall) || (res_valid && !res_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_streaming_source_tokenizer failed");
			$finish;
		end
	end

	initial begin
		tok_res_t fixed_res;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PROBE_ROWS; i++) begin
			fixed_res = '0;
			fixed_res.kind = probe_rows[i].kind;
			fixed_res.err = probe_rows[i].err;
			fixed_res.ln = 16'd1;
			fixed_res.col = 16'd1;
			fixed_res.lst = 1'b1;
			push_text(probe_rows[i].c, probe_rows[i].e, probe_rows[i].fixed, fixed_res);
		end

		while (live_items < PROBE_ROWS + RANDOM_ITEMS / 2) begin
			send_piece();
		end
		send_eot();
		hold_until_drained();

		while (live_items < PROBE_ROWS + RANDOM_ITEMS) begin
			send_piece();
		end
		send_eot();

		text_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_streaming_source_tokenizer passed");
		end else begin
			$display("tb_streaming_source_tokenizer failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/sst_pkg.sv
hw/rtl/streaming_source_tokenizer.sv
tb/tb_streaming_source_tokenizer.sv
